### src/srwn_pkg.sv
// ----------------------------------------------------------------------------
// srwn_pkg
// Shared types and constants for the scale random walk note generator.
// ----------------------------------------------------------------------------
package srwn_pkg;

  localparam int IDX_W   = 4;
  localparam int OCT_W   = 5;
  localparam int NOTE_W  = 8;
  localparam int ROOT_W  = 7;
  localparam int LEN_W   = 4;
  localparam int TABLE_W = 48;
  localparam int PC_W    = 4;

  localparam logic [1:0] CFG_ROOT   = 2'd0;
  localparam logic [1:0] CFG_LENGTH = 2'd1;
  localparam logic [1:0] CFG_TABLE  = 2'd2;

  localparam logic [0:0] OP_STEP = 1'b0;
  localparam logic [0:0] OP_LOAD = 1'b1;

  localparam logic [1:0] DIR_DOWN = 2'd0;
  localparam logic [1:0] DIR_SAME = 2'd1;

  localparam logic [OCT_W-1:0] TOP_OCTAVE = 5'd8;

  // divide by 12: (x * 171) >> 11 is exact for x below 512
  localparam logic [7:0] DIV12_MUL   = 8'd171;
  localparam int         DIV12_SHIFT = 11;

  localparam logic [NOTE_W-1:0] NOTE_MAX = 8'd255;

  typedef struct packed {
    logic [0:0]        opcode;
    logic [NOTE_W-1:0] load_value;
    logic [1:0]        step_direction;
  } in_item_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note_out;
    logic              not_in_scale;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic load_res;
    logic err_res;
    logic split;
    logic inc_idx;
    logic move;
    logic note;
    logic commit;
  } srwn_cmd_t;

  typedef struct packed {
    logic is_load;
    logic below_root;
    logic hit;
    logic last;
    logic out_free;
  } srwn_sts_t;

endpackage

### src/scale_random_walk_note.sv
// A load or below-root item goes from the input register via the split state to finish;
// a step item runs the scale search, one entry per cycle up to the matched entry, then
// the move and note states; a missing pitch class is flagged when the search ends.
// Finish waits for a free output buffer; a new item is taken only after the commit.
// A finished result waits in the output buffer while the next item is processed.
// Reset (rst_n low, synchronous): note 0, root 0, length 7, table 0, no result pending.
// ----------------------------------------------------------------------------
// scale_random_walk_note
// Random walk over a configured scale, at most one degree per step item.
// ----------------------------------------------------------------------------
module scale_random_walk_note
  import srwn_pkg::*;
#(
  parameter int MAX_SCALE = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [TABLE_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  srwn_cmd_t cmd;
  srwn_sts_t sts;

  srwn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srwn_dp #(
    .MAX_SCALE (MAX_SCALE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### src/srwn_ctrl.sv
// ----------------------------------------------------------------------------
// srwn_ctrl
// Sequencer for split, scale search, degree move, note build and commit.
// ----------------------------------------------------------------------------
module srwn_ctrl
  import srwn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  srwn_sts_t sts,
  output srwn_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SPLIT  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_NOTE   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (sts.is_load) begin
          cmd.load_res = 1'b1;
          state_nxt    = S_FIN;
        end else if (sts.below_root) begin
          cmd.err_res = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.split = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.hit) begin
          state_nxt = S_MOVE;
        end else if (sts.last) begin
          cmd.err_res = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_NOTE;
      end
      S_NOTE: begin
        cmd.note  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/srwn_dp.sv
// ----------------------------------------------------------------------------
// srwn_dp
// Configuration registers, current note, search registers and result buffer.
// ----------------------------------------------------------------------------
module srwn_dp
  import srwn_pkg::*;
#(
  parameter int MAX_SCALE = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [TABLE_W-1:0] cfg_wdata,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  srwn_cmd_t          cmd,
  output srwn_sts_t          sts
);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SCALE);

  logic [ROOT_W-1:0]  root_r;
  logic [LEN_W-1:0]   len_cfg_r;
  logic [TABLE_W-1:0] table_r;
  logic [NOTE_W-1:0]  cur_r;
  in_item_t           item_r;
  logic [IDX_W-1:0]   idx_r;
  logic [OCT_W-1:0]   oct_r;
  logic [PC_W-1:0]    pc_r;
  logic [NOTE_W-1:0]  res_note_r;
  logic               res_err_r;
  out_item_t          out_r;
  logic               out_valid_r;

  logic [LEN_W-1:0]   len;
  logic [IDX_W-1:0]   len_m1;
  logic [NOTE_W-1:0]  rel;
  logic [15:0]        prod;
  logic [OCT_W-1:0]   oct_q;
  logic [NOTE_W-1:0]  oct_x12;
  logic [PC_W-1:0]    entry;
  logic [8:0]         oct_r_x12;
  logic [9:0]         note_sum;

  always_comb begin
    len = len_cfg_r;
    if (len == '0) begin
      len = LEN_W'(1);
    end
    if (len > LEN_MAX) begin
      len = LEN_MAX;
    end
  end

  assign len_m1    = len - IDX_W'(1);
  assign rel       = cur_r - {1'b0, root_r};
  assign prod      = rel * DIV12_MUL;
  assign oct_q     = prod[DIV12_SHIFT +: OCT_W];
  assign oct_x12   = {oct_q[4:0], 3'b000} + {1'b0, oct_q[4:0], 2'b00};
  assign entry     = table_r[{idx_r, 2'b00} +: PC_W];
  assign oct_r_x12 = {1'b0, oct_r, 3'b000} + {2'b00, oct_r, 2'b00};
  assign note_sum  = {6'd0, entry} + {1'b0, oct_r_x12} + {3'd0, root_r};

  assign sts.is_load    = (item_r.opcode == OP_LOAD);
  assign sts.below_root = (cur_r < {1'b0, root_r});
  assign sts.hit        = (entry == pc_r);
  assign sts.last       = (idx_r == len_m1);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r    <= '0;
      len_cfg_r <= LEN_W'(7);
      table_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROOT:   root_r    <= cfg_wdata[ROOT_W-1:0];
        CFG_LENGTH: len_cfg_r <= cfg_wdata[LEN_W-1:0];
        CFG_TABLE:  table_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.split) begin
      oct_r <= oct_q;
      pc_r  <= PC_W'(rel - oct_x12);
      idx_r <= '0;
    end
    if (cmd.inc_idx) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.move) begin
      if (item_r.step_direction == DIR_DOWN) begin
        if (idx_r != '0) begin
          idx_r <= idx_r - IDX_W'(1);
        end else begin
          idx_r <= len_m1;
          if (oct_r != '0) begin
            oct_r <= oct_r - OCT_W'(1);
          end
        end
      end else if (item_r.step_direction != DIR_SAME) begin
        if (idx_r < len_m1) begin
          idx_r <= idx_r + IDX_W'(1);
        end else begin
          idx_r <= '0;
          if (oct_r < TOP_OCTAVE) begin
            oct_r <= oct_r + OCT_W'(1);
          end
        end
      end
    end
    if (cmd.load_res) begin
      res_note_r <= item_r.load_value;
      res_err_r  <= 1'b0;
    end
    if (cmd.err_res) begin
      res_note_r <= cur_r;
      res_err_r  <= 1'b1;
    end
    if (cmd.note) begin
      res_note_r <= (note_sum > {2'b00, NOTE_MAX}) ? NOTE_MAX : note_sum[NOTE_W-1:0];
      res_err_r  <= 1'b0;
    end
    if (cmd.commit) begin
      out_r.note_out     <= res_note_r;
      out_r.not_in_scale <= res_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        cur_r       <= res_note_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit while result buffer is occupied");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.inc_idx |-> (idx_r < len_m1))
    else $error("scale search ran past the active length");

  a_note_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.note |-> (idx_r < len))
    else $error("scale degree outside the active length");

  a_commit_note: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid_r && (cur_r == out_r.note_out)))
    else $error("stored note differs from returned note");
`endif

endmodule

### sim/tb_scale_random_walk_note.sv
// ----------------------------------------------------------------------------
// tb_scale_random_walk_note
// Self-checking bench for the scale random walk note generator. A behavioral
// walk predictor tracks the note and the scale setup; each result transfer is
// compared with the oldest predicted note. Directed walks cover wraps, octave
// limits, saturation, error cases and length extremes, then random phases
// with random scales, loads and steps run under random input gaps and
// output stalls.
// ----------------------------------------------------------------------------
module tb_scale_random_walk_note;
  import srwn_pkg::*;

  localparam int SCALE_MAX = 12;
  localparam int SEMI      = 12;

  localparam logic [1:0] CFG_SPARE  = 2'd3;
  localparam logic [1:0] DIR_UP     = 2'd2;
  localparam logic [1:0] DIR_UP_ALT = 2'd3;

  localparam logic [TABLE_W-1:0] MAJOR     = 48'hFFFF_FB97_5420;
  localparam logic [TABLE_W-1:0] CHROMATIC = 48'hBA98_7654_3210;
  localparam logic [TABLE_W-1:0] TWIN_ROOT = 48'hFFFF_FFFF_F400;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = CFG_ROOT;
  logic [TABLE_W-1:0] cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;

  logic [NOTE_W-1:0]  walk_note  = '0;
  logic [ROOT_W-1:0]  walk_root  = '0;
  logic [LEN_W-1:0]   walk_len   = 4'd7;
  logic [TABLE_W-1:0] walk_table = '0;

  out_item_t   expected_notes[$];
  int unsigned fail_count = 0;
  bit          rush_in    = 1'b0;
  bit          rush_out   = 1'b0;

  scale_random_walk_note #(
    .MAX_SCALE(SCALE_MAX)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned active_span();
    if (walk_len == 0) return 1;
    if (walk_len > SCALE_MAX) return SCALE_MAX;
    return walk_len;
  endfunction

  function automatic logic [PC_W-1:0] entry_at(input int unsigned pos);
    return walk_table[pos*PC_W +: PC_W];
  endfunction

  function automatic out_item_t walk_step(input in_item_t item);
    out_item_t   res;
    int unsigned span, rel, octave, pclass, pos, sum, i;
    bit          hit;
    res.not_in_scale = 1'b0;
    hit = 1'b0;
    pos = 0;
    if (item.opcode == OP_LOAD) begin
      walk_note = item.load_value;
    end else if (walk_note < walk_root) begin
      res.not_in_scale = 1'b1;
    end else begin
      span   = active_span();
      rel    = walk_note - walk_root;
      octave = rel / SEMI;
      pclass = rel % SEMI;
      // lowest matching entry wins
      for (i = span; i > 0; i--) begin
        if (entry_at(i - 1) == pclass) begin
          hit = 1'b1;
          pos = i - 1;
        end
      end
      if (!hit) begin
        res.not_in_scale = 1'b1;
      end else begin
        if (item.step_direction == DIR_DOWN) begin
          if (pos > 0) begin
            pos--;
          end else begin
            pos = span - 1;
            if (octave > 0) octave--;
          end
        end else if (item.step_direction != DIR_SAME) begin
          if (pos < span - 1) begin
            pos++;
          end else begin
            pos = 0;
            if (octave < TOP_OCTAVE) octave++;
          end
        end
        sum = entry_at(pos) + octave * SEMI + walk_root;
        walk_note = (sum > NOTE_MAX) ? NOTE_MAX : sum[NOTE_W-1:0];
      end
    end
    res.note_out = walk_note;
    return res;
  endfunction

  function automatic in_item_t load_item(input logic [NOTE_W-1:0] value);
    in_item_t it;
    it.opcode         = OP_LOAD;
    it.load_value     = value;
    it.step_direction = 2'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic in_item_t step_item(input logic [1:0] dir);
    in_item_t it;
    it.opcode         = OP_STEP;
    it.load_value     = NOTE_W'($urandom_range(0, 255));
    it.step_direction = dir;
    return it;
  endfunction

  // a note on the active scale at a random octave, saturated at the top note
  function automatic logic [NOTE_W-1:0] scale_note();
    int unsigned sum;
    sum = entry_at($urandom_range(0, active_span() - 1)) + SEMI * $urandom_range(0, 10)
          + walk_root;
    return (sum > NOTE_MAX) ? NOTE_MAX : sum[NOTE_W-1:0];
  endfunction

  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = rush_in ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_notes.push_back(walk_step(item));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [TABLE_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_ROOT:   walk_root  = value[ROOT_W-1:0];
      CFG_LENGTH: walk_len   = value[LEN_W-1:0];
      CFG_TABLE:  walk_table = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_notes.size() != 0) @(posedge clk);
  endtask

  task automatic apply_config(input logic [ROOT_W-1:0] root, input logic [LEN_W-1:0] len,
                              input logic [TABLE_W-1:0] tbl);
    logic [TABLE_W-1:0] noise;
    drain();
    // unused upper bits carry noise
    noise = TABLE_W'({$urandom, $urandom});
    write_reg(CFG_ROOT, {noise[TABLE_W-1:ROOT_W], root});
    noise = TABLE_W'({$urandom, $urandom});
    write_reg(CFG_LENGTH, {noise[TABLE_W-1:LEN_W], len});
    write_reg(CFG_TABLE, tbl);
    write_reg(CFG_SPARE, TABLE_W'({$urandom, $urandom}));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic make_scale(output logic [TABLE_W-1:0] tbl, output logic [LEN_W-1:0] count);
    int unsigned pc;
    tbl   = TABLE_W'({$urandom, $urandom});
    count = '0;
    for (pc = 0; pc < SEMI; pc++) begin
      if ($urandom_range(0, 1) == 1 || (pc == SEMI - 1 && count == 0)) begin
        tbl[count*PC_W +: PC_W] = PC_W'(pc);
        count++;
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_item(step_item(DIR_UP));
  endtask

  task automatic test_directed_walk();
    apply_config(7'd60, 4'd7, MAJOR);
    send_item(load_item(8'd60));
    send_item(step_item(DIR_UP));
    send_item(step_item(DIR_UP_ALT));
    send_item(step_item(DIR_SAME));
    send_item(step_item(DIR_DOWN));
    send_item(step_item(DIR_DOWN));
    send_item(step_item(DIR_DOWN));
    // below root
    send_item(load_item(8'd59));
    send_item(step_item(DIR_UP));
    // pitch class missing
    send_item(load_item(8'd61));
    send_item(step_item(DIR_DOWN));
  endtask

  task automatic test_top_octaves();
    apply_config(7'd0, 4'd7, MAJOR);
    send_item(load_item(8'd107));
    send_item(step_item(DIR_UP));
    // octave above the top after a load
    send_item(load_item(8'd179));
    send_item(step_item(DIR_UP));
    send_item(step_item(DIR_DOWN));
    // saturation at the top note
    apply_config(7'd127, 4'd7, MAJOR);
    send_item(load_item(8'd252));
    send_item(step_item(DIR_UP));
    send_item(step_item(DIR_UP));
    send_item(step_item(DIR_UP));
  endtask

  task automatic test_length_limits();
    apply_config(7'd5, 4'd0, MAJOR);
    send_item(load_item(8'd5));
    send_item(step_item(DIR_UP));
    send_item(step_item(DIR_DOWN));
    apply_config(7'd0, 4'd15, CHROMATIC);
    send_item(load_item(8'd11));
    send_item(step_item(DIR_UP));
    // duplicate entries
    apply_config(7'd0, 4'd3, TWIN_ROOT);
    send_item(load_item(8'd0));
    send_item(step_item(DIR_UP));
    send_item(step_item(DIR_DOWN));
  endtask

  task automatic test_random_walk();
    int unsigned        phase, n, pick;
    logic [TABLE_W-1:0] tbl;
    logic [LEN_W-1:0]   count;
    for (phase = 0; phase < 20; phase++) begin
      make_scale(tbl, count);
      case (phase % 6)
        0: apply_config(ROOT_W'($urandom_range(0, 127)), count, tbl);
        1: apply_config(7'd0, LEN_W'(SCALE_MAX), CHROMATIC);
        2: apply_config(7'd127, count, tbl);
        3: apply_config(ROOT_W'($urandom_range(0, 127)), LEN_W'($urandom_range(0, 15)),
                        TABLE_W'({$urandom, $urandom}));
        4: apply_config(ROOT_W'($urandom_range(0, 127)), 4'd1, tbl);
        default: apply_config(ROOT_W'($urandom_range(0, 127)),
                              $urandom_range(0, 1) ? 4'd15 : 4'd0, tbl);
      endcase
      rush_in  = ($urandom_range(0, 3) == 0);
      rush_out = ($urandom_range(0, 3) == 0);
      send_item(load_item(scale_note()));
      for (n = 0; n < 70; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          send_item(load_item(scale_note()));
        end else if (pick < 14) begin
          send_item(load_item(NOTE_W'($urandom_range(0, 255))));
        end else begin
          send_item(step_item(2'($urandom_range(0, 3))));
        end
      end
    end
    rush_in  = 1'b0;
    rush_out = 1'b0;
  endtask

  initial begin : result_check
    int unsigned stall;
    out_item_t   want;
    wait (rst_n === 1'b1);
    forever begin
      stall = rush_out ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_notes.size() == 0) begin
        $error("unexpected result transfer: note_out %0d", out_data.note_out);
        fail_count++;
      end else begin
        want = expected_notes.pop_front();
        if (out_data.note_out !== want.note_out) begin
          $error("note_out: expected %0d, got %0d", want.note_out, out_data.note_out);
          fail_count++;
        end
        if (out_data.not_in_scale !== want.not_in_scale) begin
          $error("not_in_scale: expected %0d, got %0d", want.not_in_scale,
                 out_data.not_in_scale);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned w;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_walk();
    test_top_octaves();
    test_length_limits();
    test_random_walk();
    in_valid <= 1'b0;
    for (w = 0; w < 2000 && expected_notes.size() != 0; w++) @(posedge clk);
    if (expected_notes.size() != 0) begin
      $error("note_out: %0d expected results never arrived", expected_notes.size());
      fail_count++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
